### src/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AVT_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define AVT_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/avt_pkg.sv
// Types, codes and constants of the address vector table.
`timescale 1ns / 1ps

package avt_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned ADDR_W       = 64;
  localparam int unsigned TS_W         = 11;
  localparam int unsigned RX_W         = 5;
  localparam int unsigned RIDX_W       = 10;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = TS_W;

  localparam logic [TS_W-1:0] TS_RESET = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CTX_BITS   = 1'b1;

  localparam logic [2:0] REQ_INSERT  = 3'd0;
  localparam logic [2:0] REQ_RESERVE = 3'd1;
  localparam logic [2:0] REQ_FILL    = 3'd2;
  localparam logic [2:0] REQ_REMOVE  = 3'd3;
  localparam logic [2:0] REQ_LOOKUP  = 3'd4;
  localparam logic [2:0] REQ_REVERSE = 3'd5;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_RANGE     = 3'd1;
  localparam logic [2:0] STATUS_NOT_VALID = 3'd2;
  localparam logic [2:0] STATUS_FULL      = 3'd3;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [ADDR_W-1:0] fabric_addr;
    logic [31:0]       peer_nic;
    logic [15:0]       peer_pid;
  } avt_req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [RIDX_W-1:0] result_index;
    logic [31:0]       result_nic;
    logic [15:0]       result_pid;
  } avt_rsp_t;

  typedef struct packed {
    logic [TS_W-1:0] table_size;
    logic [RX_W-1:0] ctx_bits;
  } avt_cfg_t;

  typedef struct packed {
    logic [31:0] nic;
    logic [15:0] pid;
    logic        valid;
    logic        alloc;
  } avt_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_ACCESS
  } avt_state_t;

endpackage

### src/address_vector_table.sv
// Address vector table top level: configuration registers, sequencer and entry store.
// In-range fill, remove, lookup and high-water allocation pass from dispatch through the access
// state before done is raised; a request that touches no entry raises done from dispatch.
// Scanned allocation and reverse lookup visit the entries in order up to the used table size;
// a new request is taken in the cycle done is high, one at a time.
// After reset busy stays high while the store is cleared.
`timescale 1ns / 1ps

module address_vector_table #(
  parameter int unsigned CAPACITY = avt_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  avt_pkg::avt_req_t                  request,
  output logic                               done,
  output avt_pkg::avt_rsp_t                  response,
  input  logic                               cfg_we,
  input  logic [avt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [avt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import avt_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);

  avt_cfg_t         cfg;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  avt_entry_t       mem_wdata;
  avt_entry_t       mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.table_size <= TS_RESET;
      cfg.ctx_bits   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TABLE_SIZE: cfg.table_size <= cfg_data[TS_W-1:0];
        REG_CTX_BITS:   cfg.ctx_bits   <= cfg_data[RX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  avt_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .cfg      (cfg),
    .done     (done),
    .response (response),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  avt_mem #(
    .CAPACITY(CAPACITY)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

### src/avt_mem.sv
// Entry store: one write port and one registered read port.
`timescale 1ns / 1ps

module avt_mem #(
  parameter int unsigned CAPACITY = avt_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(CAPACITY)-1:0] waddr,
  input  avt_pkg::avt_entry_t         wdata,
  input  logic [$clog2(CAPACITY)-1:0] raddr,
  output avt_pkg::avt_entry_t         rdata
);
  import avt_pkg::*;

  avt_entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/avt_ctrl.sv
// Request sequencer: clearing pass, index decode, entry scan and update.
`timescale 1ns / 1ps

module avt_ctrl #(
  parameter int unsigned CAPACITY = avt_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  avt_pkg::avt_req_t           request,
  input  avt_pkg::avt_cfg_t           cfg,
  output logic                        done,
  output avt_pkg::avt_rsp_t           response,
  output logic                        mem_we,
  output logic [$clog2(CAPACITY)-1:0] mem_waddr,
  output avt_pkg::avt_entry_t         mem_wdata,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr,
  input  avt_pkg::avt_entry_t         mem_rdata
);
  import avt_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);

  avt_state_t        state, state_next;
  avt_req_t          req, req_next;
  logic [IDX_W-1:0]  tgt, tgt_next;
  logic [IDX_W-1:0]  chk_idx, chk_idx_next;
  logic [IDX_W-1:0]  clr_idx, clr_idx_next;
  logic [TS_W-1:0]   high_water, high_water_next;
  avt_rsp_t          rsp_next;
  logic              done_next;

  logic [31:0]       size_ext;
  logic [TS_W-1:0]   used_size;
  logic [ADDR_W-1:0] masked_addr;
  logic [IDX_W-1:0]  dec_idx;
  logic              in_range;
  logic              addr_all_ones;
  logic              is_alloc;
  logic              is_insert;
  logic              alloc_fast;
  logic              go_scan;
  logic              go_access;
  logic              scan_hit;
  logic              scan_last;
  logic              clr_last;

  assign size_ext  = (32'(cfg.table_size) > CAPACITY) ? CAPACITY : 32'(cfg.table_size);
  assign used_size = TS_W'(size_ext);

  assign masked_addr   = req.fabric_addr & ({ADDR_W{1'b1}} >> cfg.ctx_bits);
  assign in_range      = masked_addr < ADDR_W'(used_size);
  assign dec_idx       = IDX_W'(masked_addr);
  assign addr_all_ones = &req.fabric_addr;

  assign is_insert  = req.req_type == REQ_INSERT;
  assign is_alloc   = is_insert || (req.req_type == REQ_RESERVE);
  assign alloc_fast = high_water < used_size;

  assign scan_hit  = is_alloc ? !mem_rdata.alloc
                              : (mem_rdata.nic == req.peer_nic) && (mem_rdata.pid == req.peer_pid);
  assign scan_last = (32'(chk_idx) + 32'd1) == 32'(used_size);
  assign clr_last  = 32'(clr_idx) == (CAPACITY - 1);

  always_comb begin
    go_scan   = 1'b0;
    go_access = 1'b0;
    unique case (req.req_type)
      REQ_INSERT, REQ_RESERVE: begin
        go_access = alloc_fast;
        go_scan   = !alloc_fast && (used_size != '0);
      end
      REQ_FILL, REQ_LOOKUP: begin
        go_access = in_range;
      end
      REQ_REMOVE: begin
        go_access = in_range && !addr_all_ones;
      end
      REQ_REVERSE: begin
        go_scan = used_size != '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        priority if (go_scan) state_next = ST_SCAN;
        else if (go_access) state_next = ST_ACCESS;
        else state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_hit || scan_last) state_next = ST_IDLE;
      end
      ST_ACCESS: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_next        = req;
    tgt_next        = tgt;
    chk_idx_next    = chk_idx;
    clr_idx_next    = clr_idx;
    high_water_next = high_water;
    rsp_next        = '0;
    done_next       = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = tgt;
    mem_wdata       = mem_rdata;
    mem_raddr       = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_idx;
        mem_wdata    = '0;
        clr_idx_next = clr_idx + IDX_W'(1);
      end
      ST_IDLE: begin
        if (start) req_next = request;
      end
      ST_DISPATCH: begin
        if (go_scan) begin
          chk_idx_next = '0;
        end else if (go_access) begin
          if (is_alloc) begin
            mem_raddr       = IDX_W'(high_water);
            tgt_next        = IDX_W'(high_water);
            high_water_next = high_water + TS_W'(1);
          end else begin
            mem_raddr = dec_idx;
            tgt_next  = dec_idx;
          end
        end else begin
          done_next = 1'b1;
          unique case (req.req_type)
            REQ_INSERT, REQ_RESERVE: rsp_next.status = STATUS_FULL;
            REQ_FILL, REQ_LOOKUP:    rsp_next.status = STATUS_RANGE;
            REQ_REMOVE:  rsp_next.status = addr_all_ones ? STATUS_OK : STATUS_RANGE;
            REQ_REVERSE: rsp_next.status = STATUS_NOT_FOUND;
            default:     rsp_next.status = STATUS_OK;
          endcase
        end
      end
      ST_SCAN: begin
        mem_raddr = chk_idx + IDX_W'(1);
        if (scan_hit) begin
          done_next             = 1'b1;
          rsp_next.result_index = RIDX_W'(chk_idx);
          if (is_alloc) begin
            mem_we          = 1'b1;
            mem_waddr       = chk_idx;
            mem_wdata.alloc = 1'b1;
            if (is_insert) begin
              mem_wdata.nic   = req.peer_nic;
              mem_wdata.pid   = req.peer_pid;
              mem_wdata.valid = 1'b1;
            end
          end
        end else if (scan_last) begin
          done_next       = 1'b1;
          rsp_next.status = is_alloc ? STATUS_FULL : STATUS_NOT_FOUND;
        end else begin
          chk_idx_next = chk_idx + IDX_W'(1);
        end
      end
      ST_ACCESS: begin
        done_next = 1'b1;
        unique case (req.req_type)
          REQ_INSERT: begin
            mem_we                = 1'b1;
            mem_wdata.nic         = req.peer_nic;
            mem_wdata.pid         = req.peer_pid;
            mem_wdata.valid       = 1'b1;
            mem_wdata.alloc       = 1'b1;
            rsp_next.result_index = RIDX_W'(tgt);
          end
          REQ_RESERVE: begin
            mem_we                = 1'b1;
            mem_wdata.alloc       = 1'b1;
            rsp_next.result_index = RIDX_W'(tgt);
          end
          REQ_FILL: begin
            mem_we          = 1'b1;
            mem_wdata.nic   = req.peer_nic;
            mem_wdata.pid   = req.peer_pid;
            mem_wdata.valid = 1'b1;
          end
          REQ_REMOVE: begin
            mem_we          = 1'b1;
            mem_wdata.valid = 1'b0;
            mem_wdata.alloc = 1'b0;
          end
          REQ_LOOKUP: begin
            if (mem_rdata.valid) begin
              rsp_next.result_nic = mem_rdata.nic;
              rsp_next.result_pid = mem_rdata.pid;
            end else begin
              rsp_next.status = STATUS_NOT_VALID;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      high_water <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      clr_idx    <= clr_idx_next;
      high_water <= high_water_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    req      <= req_next;
    tgt      <= tgt_next;
    chk_idx  <= chk_idx_next;
    response <= rsp_next;
  end

  assign busy = state != ST_IDLE;

endmodule

### src/avt_checker.sv
// Port-level checker for the address vector table, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module avt_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input avt_pkg::avt_rsp_t response
);
  import avt_pkg::*;

  logic status_known;
  logic err_shown;
  logic addr_shown;

  assign status_known = (response.status == STATUS_OK) || (response.status == STATUS_RANGE) ||
                        (response.status == STATUS_NOT_VALID) ||
                        (response.status == STATUS_FULL) ||
                        (response.status == STATUS_NOT_FOUND);
  assign err_shown    = done && (response.status != STATUS_OK);
  assign addr_shown   = (response.result_nic != '0) || (response.result_pid != '0);

  `AVT_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "busy not raised after accept")
  `AVT_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "result shown while still busy")
  `AVT_ASSERT_NXT(a_done_single, clk, rst, done, !done, "result strobe longer than one cycle")
  `AVT_ASSERT_IMP(a_status_code, clk, rst, done, status_known, "unknown status code")
  `AVT_ASSERT_IMP(a_err_no_addr, clk, rst, err_shown, !addr_shown, "address returned with error")

endmodule

bind address_vector_table avt_checker u_avt_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .response(response)
);

### tb/tb.sv
// Self-checking testbench for the address vector table: random and directed requests.
`timescale 1ns / 1ps

module tb;
  import avt_pkg::*;

  localparam logic [2:0]  REQ_UNUSED_LO = 3'd6;
  localparam logic [2:0]  REQ_UNUSED_HI = 3'd7;
  localparam logic [63:0] ALL_ONES      = '1;
  localparam int          CALM_TAIL     = 60;

  typedef struct {
    bit                    is_cfg;
    int                    hold;
    avt_req_t              req;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
  } pending_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  avt_req_t              request = '0;
  logic                  done;
  avt_rsp_t              response;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pending_t pending [$];
  avt_rsp_t predicted_rsp [$];
  int       n_issued = 0;
  int       n_answered = 0;
  int       n_errors = 0;
  int       hold_left = 0;
  bit       hold_loaded = 1'b0;

  bit [31:0]   nic_tbl [CAPACITY_DEF];
  bit [15:0]   pid_tbl [CAPACITY_DEF];
  bit          valid_tbl [CAPACITY_DEF];
  bit          alloc_tbl [CAPACITY_DEF];
  bit [TS_W-1:0] hw_mark = '0;
  bit [TS_W-1:0] size_cfg = TS_RESET;
  bit [RX_W-1:0] rx_cfg = '0;

  address_vector_table dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .response  (response),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic avt_req_t make_request(logic [2:0] kind, logic [63:0] fa,
                                            logic [31:0] nic, logic [15:0] pid);
    avt_req_t r;
    r.req_type    = kind;
    r.fabric_addr = fa;
    r.peer_nic    = nic;
    r.peer_pid    = pid;
    return r;
  endfunction

  function automatic void queue_request(avt_req_t r, int hold);
    pending_t p;
    p.is_cfg    = 1'b0;
    p.hold      = hold;
    p.req       = r;
    p.reg_index = '0;
    p.reg_value = '0;
    pending.push_back(p);
  endfunction

  function automatic void queue_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    pending_t p;
    p.is_cfg    = 1'b1;
    p.hold      = 0;
    p.req       = '0;
    p.reg_index = idx;
    p.reg_value = val;
    pending.push_back(p);
  endfunction

  function automatic int slot_of(logic [63:0] fa, int used);
    logic [63:0] v;
    v = fa & (ALL_ONES >> rx_cfg);
    if (v >= 64'(used)) return -1;
    return int'(v);
  endfunction

  function automatic avt_rsp_t predict_response(avt_req_t r);
    avt_rsp_t rsp;
    int       used;
    int       slot;
    bit       found;
    rsp = '0;
    used = (size_cfg > CAPACITY_DEF) ? int'(CAPACITY_DEF) : int'(size_cfg);
    found = 1'b0;
    case (r.req_type)
      REQ_INSERT, REQ_RESERVE: begin
        slot = -1;
        if (hw_mark < used) begin
          slot = int'(hw_mark);
          hw_mark = hw_mark + TS_W'(1);
        end else begin
          for (int i = 0; i < used; i++)
            if (!found && !alloc_tbl[i]) begin
              slot = i;
              found = 1'b1;
            end
        end
        if (slot < 0) begin
          rsp.status = STATUS_FULL;
        end else begin
          alloc_tbl[slot] = 1'b1;
          rsp.result_index = RIDX_W'(slot);
          if (r.req_type == REQ_INSERT) begin
            nic_tbl[slot] = r.peer_nic;
            pid_tbl[slot] = r.peer_pid;
            valid_tbl[slot] = 1'b1;
          end
        end
      end
      REQ_FILL: begin
        slot = slot_of(r.fabric_addr, used);
        if (slot < 0) begin
          rsp.status = STATUS_RANGE;
        end else begin
          nic_tbl[slot] = r.peer_nic;
          pid_tbl[slot] = r.peer_pid;
          valid_tbl[slot] = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (r.fabric_addr != ALL_ONES) begin
          slot = slot_of(r.fabric_addr, used);
          if (slot < 0) begin
            rsp.status = STATUS_RANGE;
          end else begin
            valid_tbl[slot] = 1'b0;
            alloc_tbl[slot] = 1'b0;
          end
        end
      end
      REQ_LOOKUP: begin
        slot = slot_of(r.fabric_addr, used);
        if (slot < 0) begin
          rsp.status = STATUS_RANGE;
        end else if (!valid_tbl[slot]) begin
          rsp.status = STATUS_NOT_VALID;
        end else begin
          rsp.result_nic = nic_tbl[slot];
          rsp.result_pid = pid_tbl[slot];
        end
      end
      REQ_REVERSE: begin
        rsp.status = STATUS_NOT_FOUND;
        for (int i = 0; i < used; i++)
          if (!found && nic_tbl[i] == r.peer_nic && pid_tbl[i] == r.peer_pid) begin
            found = 1'b1;
            rsp.status = STATUS_OK;
            rsp.result_index = RIDX_W'(i);
          end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin : drive
    logic     take;
    logic     next_start;
    logic     next_we;
    pending_t head;
    take = start && !busy;
    next_start = 1'b0;
    next_we = 1'b0;
    if (!rst) begin
      if (take) begin
        predicted_rsp.push_back(predict_response(request));
        n_issued <= n_issued + 1;
        void'(pending.pop_front());
        hold_loaded = 1'b0;
      end
      if (pending.size() != 0) begin
        head = pending[0];
        if (head.is_cfg) begin
          if (!take && !busy && n_issued == n_answered) begin
            next_we = 1'b1;
            cfg_index <= head.reg_index;
            cfg_data <= head.reg_value;
            if (head.reg_index == REG_TABLE_SIZE)
              size_cfg = head.reg_value;
            else
              rx_cfg = head.reg_value[RX_W-1:0];
            void'(pending.pop_front());
          end
        end else begin
          if (!hold_loaded) begin
            hold_left = head.hold;
            hold_loaded = 1'b1;
          end
          if (hold_left > 0) begin
            hold_left--;
          end else begin
            next_start = 1'b1;
            request <= head.req;
          end
        end
      end
    end
    start <= next_start;
    cfg_we <= next_we;
  end

  always @(posedge clk) begin : observe
    avt_rsp_t want;
    if (!rst && done) begin
      if (n_answered >= n_issued) begin
        $display("%0t: response with no request outstanding, expected none actual %h",
                 $time, response);
        n_errors++;
      end else begin
        want = predicted_rsp[n_answered];
        check_field("status", 64'(want.status), 64'(response.status));
        check_field("result_index", 64'(want.result_index), 64'(response.result_index));
        check_field("result_nic", 64'(want.result_nic), 64'(response.result_nic));
        check_field("result_pid", 64'(want.result_pid), 64'(response.result_pid));
        n_answered <= n_answered + 1;
      end
    end
  end

  initial begin : stimulus
    logic [31:0]           pool_nic [6];
    logic [15:0]           pool_pid [6];
    logic [2:0]            kind;
    logic [63:0]           fa;
    logic [CFG_DATA_W-1:0] rx_val;
    int size, rx, len, pct;
    int used, pick, slot, left, hold;

    queue_request(make_request(REQ_INSERT, '0, '1, '1), 0);
    queue_request(make_request(REQ_INSERT, '0, '0, '0), 0);
    queue_request(make_request(REQ_RESERVE, '0, 32'h1, 16'h1), 0);
    queue_request(make_request(REQ_LOOKUP, 64'd0, '0, '0), 0);
    queue_request(make_request(REQ_LOOKUP, 64'd2, '0, '0), 0);
    queue_request(make_request(REQ_FILL, 64'd2, 32'h1234_5678, 16'habcd), 0);
    queue_request(make_request(REQ_FILL, 64'd5, 32'ha5a5_a5a5, 16'h5a5a), 0);
    queue_request(make_request(REQ_LOOKUP, 64'd5, '0, '0), 0);
    queue_request(make_request(REQ_LOOKUP, 64'd1023, '0, '0), 0);
    queue_request(make_request(REQ_LOOKUP, 64'd1024, '0, '0), 0);
    queue_request(make_request(REQ_LOOKUP, ALL_ONES, '0, '0), 0);
    queue_request(make_request(REQ_REMOVE, ALL_ONES, '0, '0), 0);
    queue_request(make_request(REQ_REMOVE, 64'd1, '0, '0), 0);
    queue_request(make_request(REQ_REVERSE, '0, '0, '0), 0);
    queue_request(make_request(REQ_REVERSE, '0, '1, '1), 0);
    queue_request(make_request(REQ_REVERSE, '0, 32'h1234_5678, 16'habcd), 0);
    queue_request(make_request(REQ_REVERSE, '0, 32'hdead_beef, 16'h1), 0);
    queue_request(make_request(REQ_UNUSED_LO, 64'd3, 32'h5, 16'h5), 0);
    queue_request(make_request(REQ_UNUSED_HI, ALL_ONES, '1, '1), 0);
    queue_request(make_request(REQ_FILL, 64'd1024, 32'h1, 16'h1), 0);
    queue_request(make_request(REQ_REMOVE, 64'd2000, '0, '0), 0);
    queue_config(REG_TABLE_SIZE, CFG_DATA_W'(2));
    queue_request(make_request(REQ_INSERT, '0, 32'h0bad_cafe, 16'h7777), 0);
    queue_request(make_request(REQ_RESERVE, '0, '0, '0), 0);
    queue_config(REG_TABLE_SIZE, CFG_DATA_W'(0));
    queue_request(make_request(REQ_RESERVE, '0, '0, '0), 0);
    queue_request(make_request(REQ_LOOKUP, 64'd0, '0, '0), 0);
    queue_request(make_request(REQ_REVERSE, '0, '0, '0), 0);

    pool_nic[0] = '0;
    pool_pid[0] = '0;
    left = 555;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin size = 16;   rx = 0;  len = 80; pct = 30; end
        1: begin size = 5;    rx = 31; len = 60; pct = 0;  end
        2: begin size = 1;    rx = 1;  len = 30; pct = 60; end
        3: begin size = 40;   rx = 16; len = 90; pct = 10; end
        4: begin size = 2047; rx = 8;  len = 30; pct = 20; end
        5: begin size = 1024; rx = 0;  len = 25; pct = 0;  end
        6: begin size = 1500; rx = 4;  len = 20; pct = 30; end
        7: begin size = 3;    rx = 2;  len = 50; pct = 40; end
        8: begin size = 24;   rx = 12; len = 90; pct = 15; end
        default: begin size = 12; rx = 0; len = 80; pct = 5; end
      endcase
      queue_config(REG_TABLE_SIZE, CFG_DATA_W'(size));
      rx_val = CFG_DATA_W'(rx);
      if (p % 2 == 1) rx_val[CFG_DATA_W-1:RX_W] = (CFG_DATA_W-RX_W)'($urandom);
      queue_config(REG_CTX_BITS, rx_val);
      used = (size > CAPACITY_DEF) ? int'(CAPACITY_DEF) : size;
      for (int k = 1; k < 6; k++) begin
        pool_nic[k] = $urandom;
        pool_pid[k] = 16'($urandom);
      end
      for (int n = 0; n < len; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) kind = REQ_INSERT;
        else if (pick < 28) kind = REQ_RESERVE;
        else if (pick < 43) kind = REQ_FILL;
        else if (pick < 60) kind = REQ_REMOVE;
        else if (pick < 80) kind = REQ_LOOKUP;
        else if (pick < 95) kind = REQ_REVERSE;
        else kind = $urandom_range(0, 1) ? REQ_UNUSED_LO : REQ_UNUSED_HI;
        slot = $urandom_range(0, used + 1);
        pick = $urandom_range(0, 99);
        if (pick < 80) fa = 64'(slot) | ({$urandom, $urandom} & ~(ALL_ONES >> rx));
        else if (pick < 95) fa = {$urandom, $urandom};
        else fa = ALL_ONES;
        left--;
        hold = 0;
        if (left >= CALM_TAIL && $urandom_range(0, 99) < pct) hold = $urandom_range(1, 13);
        slot = $urandom_range(0, 7);
        if (slot < 6)
          queue_request(make_request(kind, fa, pool_nic[slot], pool_pid[slot]), hold);
        else
          queue_request(make_request(kind, fa, $urandom, 16'($urandom)), hold);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (pending.size() != 0 || n_answered != n_issued) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (n_answered != n_issued) begin
      $display("%0t: responses missing, expected %0d actual %0d", $time, n_issued, n_answered);
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/avt_pkg.sv
src/avt_mem.sv
src/avt_ctrl.sv
src/address_vector_table.sv
src/avt_checker.sv
tb/tb.sv
